[src/fbvs_pkg.sv]
// ---------------------------------------------------------------------------
// fbvs_pkg
// Shared constants and types for the four-bone vertex skinning block.
// ---------------------------------------------------------------------------
package fbvs_pkg;

	// Q16.16 data word width
	localparam int Q_W = 32;

	// Parameter defaults
	localparam int PALETTE_BONES_DEF = 64;
	localparam int FRAC_BITS_DEF     = 16;

	// Palette layout: 3x3 row-major rotation, then translation
	localparam int WORDS_PER_BONE = 12;
	localparam int TRANS_WORD     = 9;

	// Bone index that marks an empty influence slot
	localparam logic [7:0] UNUSED_SLOT = 8'hFF;

	// Item operation codes
	localparam logic OP_PAL_WRITE = 1'b0;
	localparam logic OP_INFLUENCE = 1'b1;

	// Per-stage control of an influence in flight
	typedef struct packed {
		logic valid;    // stage holds an influence item
		logic hit;      // bone inside the palette, contributes to position
		logic nrm_en;   // contributes to normal (hit and nonzero weight)
		logic bad;      // bone index past the palette
		logic last;     // last influence of the vertex
	} fbvs_ctl_t;

endpackage

[src/fbvs_if.sv]
// ---------------------------------------------------------------------------
// fbvs_in_if / fbvs_out_if
// Valid/ready channels for skinning input items and skinned results.
// ---------------------------------------------------------------------------
interface fbvs_in_if import fbvs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  operation;
	logic [9:0]            entry_addr;
	logic signed [Q_W-1:0] entry_value;
	logic [7:0]            bone_index;
	logic signed [Q_W-1:0] weight;
	logic signed [Q_W-1:0] pos_x;
	logic signed [Q_W-1:0] pos_y;
	logic signed [Q_W-1:0] pos_z;
	logic signed [Q_W-1:0] nrm_x;
	logic signed [Q_W-1:0] nrm_y;
	logic signed [Q_W-1:0] nrm_z;
	logic                  last_influence;

	modport source (
		output valid, operation, entry_addr, entry_value, bone_index, weight,
			pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, last_influence,
		input  ready
	);
	modport sink (
		input  valid, operation, entry_addr, entry_value, bone_index, weight,
			pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, last_influence,
		output ready
	);
endinterface

interface fbvs_out_if import fbvs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic signed [Q_W-1:0] out_pos_x;
	logic signed [Q_W-1:0] out_pos_y;
	logic signed [Q_W-1:0] out_pos_z;
	logic signed [Q_W-1:0] out_nrm_x;
	logic signed [Q_W-1:0] out_nrm_y;
	logic signed [Q_W-1:0] out_nrm_z;
	logic                  bad_index_seen;

	modport source (
		output valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
			out_nrm_z, bad_index_seen,
		input  ready
	);
	modport sink (
		input  valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
			out_nrm_z, bad_index_seen,
		output ready
	);
endinterface

[src/fbvs_ram.sv]
// ---------------------------------------------------------------------------
// fbvs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module fbvs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/four_bone_vertex_skinning.sv]
// ---------------------------------------------------------------------------
// four_bone_vertex_skinning
// Linear blend skinning in fixed point: bone palette in RAM, influences
// accumulated into per-vertex position and normal sums.
// ---------------------------------------------------------------------------
//  channel | dir | carries
//  --------+-----+------------------------------------------------------
//  item    | in  | palette word write or one bone influence of a vertex
//  result  | out | skinned position, normal and bad-index flag per vertex
//
// One item is taken per cycle unless the pipeline stalls. An influence runs
// four stages: palette row read (twelve word RAMs, one per matrix word), 21
// multiplies, term sums, then saturating accumulate, which loads a finished
// vertex into the output register. Reset clears control and the sums; the
// palette holds no reset value. The pipeline stalls only while a finished
// vertex sits in the output register and another one is ready to leave.
// ---------------------------------------------------------------------------
module four_bone_vertex_skinning import fbvs_pkg::*; #(
	parameter int PALETTE_BONES = PALETTE_BONES_DEF,
	parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fbvs_in_if.sink       item,
	fbvs_out_if.source    result
);

	localparam int AW        = (PALETTE_BONES > 1) ? $clog2(PALETTE_BONES) : 1;
	localparam int PAL_WORDS = PALETTE_BONES * WORDS_PER_BONE;
	localparam int PW        = 2 * Q_W - FRAC_BITS;   // shifted product width
	localparam int SW        = PW + 2;                // sum of four terms
	localparam int XW        = SW + 1;                // accumulate width

	localparam logic signed [XW-1:0] SAT_MAX = XW'(64'sh7FFF_FFFF);
	localparam logic signed [XW-1:0] SAT_MIN = -XW'(64'sh8000_0000);

	// ------------------------------------------------------------------
	// Handshake and stall
	// ------------------------------------------------------------------
	fbvs_ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic      out_v_q;
	logic      hold;
	logic      adv;
	logic      accept;

	assign hold       = ctl_s3.valid & ctl_s3.last & out_v_q & ~result.ready;
	assign adv        = ~hold;
	assign item.ready = adv;
	assign accept     = item.valid & adv;

	// ------------------------------------------------------------------
	// Palette write address split: bone = addr / 12, word = addr % 12
	// ------------------------------------------------------------------
	logic [15:0] div_prod;
	logic [6:0]  wr_bone;
	logic [9:0]  wr_rem;
	logic [3:0]  wr_word;
	logic        wr_ok;

	assign div_prod = 16'(item.entry_addr[9:2]) * 16'd171;   // (addr/4)/3
	assign wr_bone  = div_prod[15:9];
	assign wr_rem   = item.entry_addr - 10'(wr_bone * 4'd12);
	assign wr_word  = wr_rem[3:0];
	assign wr_ok    = accept && item.operation == OP_PAL_WRITE
		&& {2'b00, item.entry_addr} < 12'(PAL_WORDS);

	// ------------------------------------------------------------------
	// Palette: one RAM per matrix word, one row per bone
	// ------------------------------------------------------------------
	logic [Q_W-1:0] mat_s1 [WORDS_PER_BONE];

	for (genvar k = 0; k < WORDS_PER_BONE; k++) begin : g_pal
		fbvs_ram #(
			.WIDTH (Q_W),
			.DEPTH (PALETTE_BONES),
			.AW    (AW)
		) u_pal (
			.clk   (clk),
			.we    (wr_ok && wr_word == 4'(k)),
			.waddr (AW'(wr_bone)),
			.wdata (item.entry_value),
			.re    (adv),
			.raddr (item.bone_index[AW-1:0]),
			.rdata (mat_s1[k])
		);
	end

	// ------------------------------------------------------------------
	// Stage 1: register influence payload alongside the palette read
	// ------------------------------------------------------------------
	logic                  bone_used;
	logic                  bone_in;
	logic signed [Q_W-1:0] w_s1;
	logic signed [Q_W-1:0] p_s1 [3];
	logic signed [Q_W-1:0] n_s1 [3];

	assign bone_used = item.bone_index != UNUSED_SLOT;
	assign bone_in   = {1'b0, item.bone_index} < 9'(PALETTE_BONES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid  <= item.valid && item.operation == OP_INFLUENCE;
			ctl_s1.hit    <= bone_used && bone_in;
			ctl_s1.nrm_en <= bone_used && bone_in && item.weight != '0;
			ctl_s1.bad    <= bone_used && !bone_in;
			ctl_s1.last   <= item.last_influence;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1    <= item.weight;
			p_s1[0] <= item.pos_x;
			p_s1[1] <= item.pos_y;
			p_s1[2] <= item.pos_z;
			n_s1[0] <= item.nrm_x;
			n_s1[1] <= item.nrm_y;
			n_s1[2] <= item.nrm_z;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: products, floor-shifted by the fraction width
	// ------------------------------------------------------------------
	logic signed [2*Q_W-1:0] full_tp [3][4];
	logic signed [2*Q_W-1:0] full_tn [3][3];
	logic signed [PW-1:0]    tp_s2 [3][4];
	logic signed [PW-1:0]    tn_s2 [3][3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				full_tp[c][r] = p_s1[r] * $signed(mat_s1[3*r + c]);
				full_tn[c][r] = n_s1[r] * $signed(mat_s1[3*r + c]);
			end
			full_tp[c][3] = w_s1 * $signed(mat_s1[TRANS_WORD + c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				for (int t = 0; t < 4; t++) begin
					tp_s2[c][t] <= full_tp[c][t][2*Q_W-1:FRAC_BITS];
				end
				for (int r = 0; r < 3; r++) begin
					tn_s2[c][r] <= full_tn[c][r][2*Q_W-1:FRAC_BITS];
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: per-component term sums, gated by slot checks
	// ------------------------------------------------------------------
	logic signed [SW-1:0] sp_s3 [3];
	logic signed [SW-1:0] sn_s3 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				sp_s3[c] <= ctl_s2.hit
					? SW'(tp_s2[c][0]) + SW'(tp_s2[c][1])
					+ SW'(tp_s2[c][2]) + SW'(tp_s2[c][3])
					: '0;
				sn_s3[c] <= ctl_s2.nrm_en
					? SW'(tn_s2[c][0]) + SW'(tn_s2[c][1]) + SW'(tn_s2[c][2])
					: '0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Accumulate with saturation
	// ------------------------------------------------------------------
	logic signed [Q_W-1:0] pos_acc_q [3];
	logic signed [Q_W-1:0] nrm_acc_q [3];
	logic                  bad_q;
	logic signed [XW-1:0]  pos_wide [3];
	logic signed [XW-1:0]  nrm_wide [3];
	logic signed [Q_W-1:0] pos_next [3];
	logic signed [Q_W-1:0] nrm_next [3];
	logic                  s3_go;
	logic                  emit;

	assign s3_go = ctl_s3.valid & adv;
	assign emit  = s3_go & ctl_s3.last;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pos_wide[c] = XW'(pos_acc_q[c]) + XW'(sp_s3[c]);
			nrm_wide[c] = XW'(nrm_acc_q[c]) + XW'(sn_s3[c]);
			if (pos_wide[c] > SAT_MAX) begin
				pos_next[c] = SAT_MAX[Q_W-1:0];
			end else if (pos_wide[c] < SAT_MIN) begin
				pos_next[c] = SAT_MIN[Q_W-1:0];
			end else begin
				pos_next[c] = pos_wide[c][Q_W-1:0];
			end
			if (nrm_wide[c] > SAT_MAX) begin
				nrm_next[c] = SAT_MAX[Q_W-1:0];
			end else if (nrm_wide[c] < SAT_MIN) begin
				nrm_next[c] = SAT_MIN[Q_W-1:0];
			end else begin
				nrm_next[c] = nrm_wide[c][Q_W-1:0];
			end
		end
	end

	// running sums, cleared at end of vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				pos_acc_q[c] <= '0;
				nrm_acc_q[c] <= '0;
			end
			bad_q <= 1'b0;
		end else if (s3_go) begin
			for (int c = 0; c < 3; c++) begin
				pos_acc_q[c] <= ctl_s3.last ? '0 : pos_next[c];
				nrm_acc_q[c] <= ctl_s3.last ? '0 : nrm_next[c];
			end
			bad_q <= ctl_s3.last ? 1'b0 : (bad_q | ctl_s3.bad);
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	logic signed [Q_W-1:0] out_pos_q [3];
	logic signed [Q_W-1:0] out_nrm_q [3];
	logic                  out_bad_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			for (int c = 0; c < 3; c++) begin
				out_pos_q[c] <= pos_next[c];
				out_nrm_q[c] <= nrm_next[c];
			end
			out_bad_q <= bad_q | ctl_s3.bad;
		end
	end

	assign result.valid          = out_v_q;
	assign result.out_pos_x      = out_pos_q[0];
	assign result.out_pos_y      = out_pos_q[1];
	assign result.out_pos_z      = out_pos_q[2];
	assign result.out_nrm_x      = out_nrm_q[0];
	assign result.out_nrm_y      = out_nrm_q[1];
	assign result.out_nrm_z      = out_nrm_q[2];
	assign result.bad_index_seen = out_bad_q;

endmodule
